// ===== hdl/hcbd_pkg.sv =====
// Shared types and constants for the chunked body decoder.
`default_nettype none

package hcbd_pkg;

  localparam int MAX_LINE   = 8192;
  localparam int COUNT_BITS = 48;
  localparam int LINE_W     = $clog2(MAX_LINE + 1);

  localparam logic [COUNT_BITS-1:0] COUNT_MAX = {COUNT_BITS{1'b1}};
  localparam logic [LINE_W-1:0]     LINE_MAX  = LINE_W'(MAX_LINE);

  localparam logic [7:0] CH_CR   = 8'h0d;
  localparam logic [7:0] CH_LF   = 8'h0a;
  localparam logic [7:0] CH_SEMI = 8'h3b;
  localparam logic [7:0] CH_SP   = 8'h20;
  localparam logic [7:0] CH_NUL  = 8'h00;

  // Configuration register indexes.
  localparam logic CFG_LEN_CHECK = 1'b0;
  localparam logic CFG_EXP_LEN   = 1'b1;

  typedef enum logic [2:0] {
    MODE_SIZE    = 3'd0,
    MODE_DATA    = 3'd1,
    MODE_TERM    = 3'd2,
    MODE_TRAILER = 3'd3,
    MODE_DONE    = 3'd4,
    MODE_ERROR   = 3'd5
  } mode_t;

  typedef enum logic [3:0] {
    ST_BUSY         = 4'd0,
    ST_COMPLETE     = 4'd1,
    ST_BAD_CRLF     = 4'd2,
    ST_NUL          = 4'd3,
    ST_BAD_HEX      = 4'd4,
    ST_LINE_LONG    = 4'd5,
    ST_UNTERMINATED = 4'd6,
    ST_TOO_MUCH     = 4'd7,
    ST_CLOSED_EARLY = 4'd8,
    ST_OVERFLOW     = 4'd9
  } status_t;

  typedef struct packed {
    status_t    status;
    logic       payload_valid;
    logic [7:0] payload_byte;
  } result_t;

endpackage

`default_nettype wire

// ===== hdl/hcbd_core.sv =====
// Parser state and per-byte next-state logic of the chunked body decoder.
`default_nettype none

module hcbd_core (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           cfg_wen,
  input  wire logic                           cfg_index,
  input  wire logic [hcbd_pkg::COUNT_BITS-1:0] cfg_wdata,
  input  wire logic                           acc,
  input  wire logic [7:0]                     data_byte,
  input  wire logic                           close_event,
  output hcbd_pkg::result_t                   res
);

  localparam int CB = hcbd_pkg::COUNT_BITS;
  localparam int LW = hcbd_pkg::LINE_W;

  logic          len_chk_r;
  logic [CB-1:0] exp_len_r;

  hcbd_pkg::mode_t   mode_r,   mode_nxt;
  hcbd_pkg::status_t status_r, status_nxt;
  hcbd_pkg::status_t fault_r,  fault_nxt;
  logic              cr_r,     cr_nxt;
  logic              skip_r,   skip_nxt;
  logic [LW-1:0]     len_r,    len_nxt;
  logic [CB-1:0]     chunk_r,  chunk_nxt;
  logic [CB-1:0]     total_r,  total_nxt;

  logic [CB-1:0] tot_inc;
  logic [CB-1:0] chunk_dec;
  logic [LW-1:0] len_inc;
  logic          line_empty;
  logic          hex_ok;
  logic [3:0]    hex_val;
  logic          valid;

  // Hex digit decode.
  always_comb begin
    hex_ok  = 1'b1;
    hex_val = 4'd0;
    if (data_byte >= 8'h30 && data_byte <= 8'h39) begin
      hex_val = 4'(data_byte - 8'h30);
    end else if (data_byte >= 8'h41 && data_byte <= 8'h46) begin
      hex_val = 4'(data_byte - 8'h37);
    end else if (data_byte >= 8'h61 && data_byte <= 8'h66) begin
      hex_val = 4'(data_byte - 8'h57);
    end else begin
      hex_ok = 1'b0;
    end
  end

  assign tot_inc    = (total_r != hcbd_pkg::COUNT_MAX) ? total_r + 1'b1 : total_r;
  assign chunk_dec  = chunk_r - 1'b1;
  assign len_inc    = (len_r < hcbd_pkg::LINE_MAX) ? len_r + 1'b1 : len_r;
  assign line_empty = (len_r <= LW'(1));

  always_comb begin
    mode_nxt   = mode_r;
    status_nxt = status_r;
    fault_nxt  = fault_r;
    cr_nxt     = cr_r;
    skip_nxt   = skip_r;
    len_nxt    = len_r;
    chunk_nxt  = chunk_r;
    total_nxt  = total_r;
    valid      = 1'b0;

    if (mode_r != hcbd_pkg::MODE_DONE && mode_r != hcbd_pkg::MODE_ERROR) begin
      if (close_event) begin
        status_nxt = (mode_r == hcbd_pkg::MODE_TRAILER) ? hcbd_pkg::ST_COMPLETE
                                                        : hcbd_pkg::ST_CLOSED_EARLY;
      end else if (mode_r == hcbd_pkg::MODE_DATA) begin
        total_nxt = tot_inc;
        if (len_chk_r && tot_inc > exp_len_r) begin
          status_nxt = hcbd_pkg::ST_TOO_MUCH;
        end else begin
          valid     = 1'b1;
          chunk_nxt = chunk_dec;
          if (chunk_dec == '0) begin
            mode_nxt  = hcbd_pkg::MODE_TERM;
            cr_nxt    = 1'b0;
            len_nxt   = '0;
            skip_nxt  = 1'b0;
            fault_nxt = hcbd_pkg::ST_BUSY;
          end
          if (len_chk_r && tot_inc == exp_len_r) begin
            status_nxt = hcbd_pkg::ST_COMPLETE;
          end
        end
      end else if (cr_r) begin
        if (data_byte != hcbd_pkg::CH_LF) begin
          status_nxt = hcbd_pkg::ST_BAD_CRLF;
        end else begin
          // End of a line: the mode decides what it meant.
          cr_nxt    = 1'b0;
          len_nxt   = '0;
          skip_nxt  = 1'b0;
          fault_nxt = hcbd_pkg::ST_BUSY;
          case (mode_r)
            hcbd_pkg::MODE_SIZE: begin
              if (fault_r != hcbd_pkg::ST_BUSY) begin
                status_nxt = fault_r;
              end else begin
                mode_nxt = (chunk_r != '0) ? hcbd_pkg::MODE_DATA : hcbd_pkg::MODE_TRAILER;
              end
            end
            hcbd_pkg::MODE_TERM: begin
              if (!line_empty) begin
                status_nxt = hcbd_pkg::ST_UNTERMINATED;
              end else begin
                mode_nxt  = hcbd_pkg::MODE_SIZE;
                chunk_nxt = '0;
              end
            end
            default: begin
              if (line_empty) begin
                status_nxt = hcbd_pkg::ST_COMPLETE;
              end
            end
          endcase
        end
      end else if (data_byte == hcbd_pkg::CH_NUL) begin
        status_nxt = hcbd_pkg::ST_NUL;
      end else begin
        len_nxt = len_inc;
        if (data_byte == hcbd_pkg::CH_CR) begin
          cr_nxt = 1'b1;
        end else if (mode_r == hcbd_pkg::MODE_SIZE && !skip_r
                     && fault_r == hcbd_pkg::ST_BUSY) begin
          if (data_byte == hcbd_pkg::CH_SEMI || data_byte == hcbd_pkg::CH_SP) begin
            skip_nxt = 1'b1;
          end else if (!hex_ok) begin
            fault_nxt = hcbd_pkg::ST_BAD_HEX;
          end else if (chunk_r[CB-1:CB-4] != 4'd0) begin
            fault_nxt = hcbd_pkg::ST_OVERFLOW;
          end else begin
            chunk_nxt = {chunk_r[CB-5:0], hex_val};
          end
        end
        if (len_inc >= hcbd_pkg::LINE_MAX) begin
          status_nxt = hcbd_pkg::ST_LINE_LONG;
        end
      end

      if (status_nxt != hcbd_pkg::ST_BUSY) begin
        mode_nxt = (status_nxt == hcbd_pkg::ST_COMPLETE) ? hcbd_pkg::MODE_DONE
                                                         : hcbd_pkg::MODE_ERROR;
      end
    end

    res.status        = status_nxt;
    res.payload_valid = valid;
    res.payload_byte  = valid ? data_byte : 8'd0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      len_chk_r <= 1'b0;
      exp_len_r <= '0;
    end else if (cfg_wen) begin
      if (cfg_index == hcbd_pkg::CFG_LEN_CHECK) begin
        len_chk_r <= cfg_wdata[0];
      end else begin
        exp_len_r <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r   <= hcbd_pkg::MODE_SIZE;
      status_r <= hcbd_pkg::ST_BUSY;
      fault_r  <= hcbd_pkg::ST_BUSY;
      cr_r     <= 1'b0;
      skip_r   <= 1'b0;
      len_r    <= '0;
      chunk_r  <= '0;
      total_r  <= '0;
    end else if (acc) begin
      mode_r   <= mode_nxt;
      status_r <= status_nxt;
      fault_r  <= fault_nxt;
      cr_r     <= cr_nxt;
      skip_r   <= skip_nxt;
      len_r    <= len_nxt;
      chunk_r  <= chunk_nxt;
      total_r  <= total_nxt;
    end
  end

endmodule

`default_nettype wire

// ===== hdl/hcbd_skid.sv =====
// Result register with a skid entry, so input stops only once both hold a result.
`default_nettype none

module hcbd_skid (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire hcbd_pkg::result_t in_res,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output hcbd_pkg::result_t      out_res
);

  logic              main_valid_r;
  logic              skid_valid_r;
  hcbd_pkg::result_t main_r;
  hcbd_pkg::result_t skid_r;
  logic              push;
  logic              pop;

  assign in_ready  = !skid_valid_r;
  assign push      = in_valid && !skid_valid_r;
  assign pop       = main_valid_r && out_ready;
  assign out_valid = main_valid_r;
  assign out_res   = main_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      main_valid_r <= 1'b0;
      skid_valid_r <= 1'b0;
    end else if (skid_valid_r) begin
      if (pop) begin
        skid_valid_r <= 1'b0;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_valid_r <= 1'b1;
      end else begin
        main_valid_r <= 1'b1;
      end
    end else if (pop) begin
      main_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid_r) begin
      if (pop) begin
        main_r <= skid_r;
      end
    end else if (push) begin
      if (main_valid_r && !pop) begin
        skid_r <= in_res;
      end else begin
        main_r <= in_res;
      end
    end
  end

endmodule

`default_nettype wire

// ===== hdl/http_chunked_body_decoder.sv =====
// Top level of the HTTP chunked transfer body decoder.
// The input stream carries one body byte per item: in_tdata[7:0] is the byte and
// in_tuser marks a connection close, in which case the byte is ignored.
// Every input item yields exactly one result item. out_tdata holds the payload
// byte (zero when none is delivered) and the 4-bit status above it; out_tuser
// flags that the item carried a payload byte. Status stays 0 while the body is
// still in progress; completion and every error code are sticky until reset.
// The configuration port writes the length check enable (index 0) and the
// expected payload length (index 1); write them only while no item is pending.
// The parser state is updated and the result registered at the edge that accepts
// the item, into the result register or, while that is held, the skid entry.
// Throughput is one item per cycle while in_tready is high.
// A two-entry output stage (result register plus skid entry) lets the block
// take one more item while a result waits; with both full, in_tready drops
// until the receiver takes an item. Synchronous reset clears the parser to the
// start of a size line, empties the output stage and clears both config registers.
`default_nettype none

module http_chunked_body_decoder (
  input  wire logic                           clk,
  input  wire logic                           rst_n,
  input  wire logic                           in_tvalid,
  output logic                                in_tready,
  input  wire logic [7:0]                     in_tdata,   // [7:0] data_byte
  input  wire logic                           in_tuser,   // [0] close_event
  output logic                                out_tvalid,
  input  wire logic                           out_tready,
  output logic [15:0]                         out_tdata,  // [7:0] payload_byte, [11:8] status
  output logic                                out_tuser,  // [0] payload_valid
  input  wire logic                           cfg_wen,
  input  wire logic                           cfg_index,
  input  wire logic [hcbd_pkg::COUNT_BITS-1:0] cfg_wdata
);

  hcbd_pkg::result_t core_res;
  hcbd_pkg::result_t out_res;
  logic              acc;

  // An item is taken whenever the skid entry is free.
  assign acc = in_tvalid && in_tready;

  hcbd_core u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_wen     (cfg_wen),
    .cfg_index   (cfg_index),
    .cfg_wdata   (cfg_wdata),
    .acc         (acc),
    .data_byte   (in_tdata),
    .close_event (in_tuser),
    .res         (core_res)
  );

  hcbd_skid u_skid (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_tvalid),
    .in_ready  (in_tready),
    .in_res    (core_res),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_res   (out_res)
  );

  // Result fields packed low to high, padded to two bytes.
  assign out_tdata = {4'd0, out_res.status, out_res.payload_byte};
  assign out_tuser = out_res.payload_valid;

endmodule

`default_nettype wire

// ===== hdl/hcbd_checker.sv =====
// Port-level checks on the chunked body decoder, bound to its top level.
`default_nettype none

module hcbd_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        in_tvalid,
  input wire logic        in_tready,
  input wire logic        out_tvalid,
  input wire logic        out_tready,
  input wire logic [15:0] out_tdata,
  input wire logic        out_tuser
);

  // A stalled result keeps its contents.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) && $stable(out_tuser))
    else $error("result changed while stalled");

  // A payload byte is delivered only while the body is busy or just completed.
  a_payload_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> (out_tdata[11:8] == 4'd0 || out_tdata[11:8] == 4'd1))
    else $error("payload delivered with an error status");

  // Without a payload the byte field reads zero.
  a_payload_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tuser |-> out_tdata[7:0] == 8'd0)
    else $error("nonzero byte without payload");

  // An accepted item always leaves a valid result on the output in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready |=> out_tvalid)
    else $error("accepted item produced no result");

endmodule

bind http_chunked_body_decoder hcbd_checker u_hcbd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .in_tvalid  (in_tvalid),
  .in_tready  (in_tready),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser)
);

`default_nettype wire
